/* hw/rtl/dcd_pkg.sv */
package dcd_pkg;

  localparam int DIST_BITS  = 26;
  localparam int SPEED_BITS = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [SPEED_BITS-1:0] SPEED_RESET = 16'd256;

  // register word index taken from paddr[CFG_ADDR_W-1:2]
  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_SPEED = 1'b0
  } dcd_reg_t;

endpackage

/* hw/rtl/dcd_in_if.sv */
interface dcd_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] source_x;
  logic signed [COORD_WIDTH-1:0] source_y;
  logic signed [COORD_WIDTH-1:0] source_z;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  logic signed [COORD_WIDTH-1:0] target_z;

  modport source (
    output valid, source_x, source_y, source_z, target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, source_x, source_y, source_z, target_x, target_y, target_z,
    output ready
  );
endinterface

/* hw/rtl/dcd_out_if.sv */
interface dcd_out_if
  import dcd_pkg::*;
#(
  parameter int DELAY_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [DIST_BITS-1:0]   distance;
  logic [DELAY_WIDTH-1:0] delay;
  logic                   speed_error;

  modport source (
    output valid, distance, delay, speed_error,
    input  ready
  );
  modport sink (
    input  valid, distance, delay, speed_error,
    output ready
  );
endinterface

/* hw/rtl/distance_conduction_delay.sv */
// throughput: one item per cycle; 3 front stages, one stage per root bit in the
//   square root chain and one stage per quotient bit in the divider chain
// a stalled output freezes the whole pipeline, nothing is dropped
// reset (rst_n low, synchronous) empties the pipeline and sets speed to 1.0 (256)
module distance_conduction_delay
  import dcd_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int DELAY_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dcd_in_if.sink                in_chan,
  dcd_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // derived widths
  localparam int DW   = COORD_WIDTH + 1;  // magnitude of a coordinate difference
  localparam int SQW  = 2 * DW;           // one squared difference
  localparam int SUMW = SQW + 2;          // sum of three squares
  localparam int RW   = SUMW / 2;         // root bits
  localparam int REMW = RW + 3;           // sqrt partial remainder
  localparam int NW   = RW + 8;           // quotient bits (distance scaled by 256)

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [SPEED_BITS-1:0] speed_r;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_ADDR_W-1:2] == REG_SPEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
    end else if (cfg_wr) begin
      speed_r <= cfg_pwdata[SPEED_BITS-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1:2] == REG_SPEED) begin
      cfg_prdata = {{(CFG_DATA_W-SPEED_BITS){1'b0}}, speed_r};
    end
  end

  // ---------------------------------------------------------------------------
  // global stall: every stage moves when the output register is free
  // ---------------------------------------------------------------------------
  logic out_v_r;
  logic en;

  assign en            = !out_v_r || out_chan.ready;
  assign in_chan.ready = en;

  // ---------------------------------------------------------------------------
  // stage 1: absolute differences per axis
  // ---------------------------------------------------------------------------
  logic          s1_v_r;
  logic [DW-1:0] s1_dx_r, s1_dy_r, s1_dz_r;

  function automatic logic [DW-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                             input logic [COORD_WIDTH-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= abs_diff(in_chan.source_x, in_chan.target_x);
      s1_dy_r <= abs_diff(in_chan.source_y, in_chan.target_y);
      s1_dz_r <= abs_diff(in_chan.source_z, in_chan.target_z);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: squares, one multiplier per axis
  // ---------------------------------------------------------------------------
  logic           s2_v_r;
  logic [SQW-1:0] s2_qx_r, s2_qy_r, s2_qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_qx_r <= SQW'(s1_dx_r) * SQW'(s1_dx_r);
      s2_qy_r <= SQW'(s1_dy_r) * SQW'(s1_dy_r);
      s2_qz_r <= SQW'(s1_dz_r) * SQW'(s1_dz_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: sum of squares, exact Q.16 mm^2
  // ---------------------------------------------------------------------------
  logic            s3_v_r;
  logic [SUMW-1:0] s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r <= SUMW'(s2_qx_r) + SUMW'(s2_qy_r) + SUMW'(s2_qz_r);
    end
  end

  // ---------------------------------------------------------------------------
  // square root: digit-by-digit, two radicand bits in and one root bit out
  // per stage, so the partial remainder stays below 2*root+1
  // ---------------------------------------------------------------------------
  logic            sq_v_r    [RW];
  logic [SUMW-1:0] sq_rad_r  [RW];
  logic [REMW-1:0] sq_rem_r  [RW];
  logic [RW-1:0]   sq_root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic            v_in;
    logic [SUMW-1:0] rad_in;
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [REMW-1:0] r2;
    logic [REMW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = s3_v_r;
      assign rad_in  = s3_sum_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_v_r[k-1];
      assign rad_in  = sq_rad_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
    end

    assign r2    = {rem_in[REMW-3:0], rad_in[SUMW-1 -: 2]};
    assign trial = REMW'({root_in, 2'b01});
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[k]  <= {rad_in[SUMW-3:0], 2'b00};
        sq_rem_r[k]  <= ge ? (r2 - trial) : r2;
        sq_root_r[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // divider: restoring, one quotient bit of (distance << 8) / speed per stage; the
  // user, not the block, ensures speed only changes while the pipeline is empty
  // ---------------------------------------------------------------------------
  logic                  dv_v_r    [NW];
  logic [NW-1:0]         dv_num_r  [NW];
  logic [SPEED_BITS-1:0] dv_rem_r  [NW];
  logic [NW-1:0]         dv_q_r    [NW];
  logic [RW-1:0]         dv_dist_r [NW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic                  v_in;
    logic [NW-1:0]         num_in;
    logic [SPEED_BITS-1:0] rem_in;
    logic [NW-1:0]         q_in;
    logic [RW-1:0]         dist_in;
    logic [SPEED_BITS:0]   r;
    logic [SPEED_BITS:0]   diff;
    logic                  ge;

    if (j == 0) begin : g_first
      assign v_in    = sq_v_r[RW-1];
      assign num_in  = {sq_root_r[RW-1], 8'h00};
      assign rem_in  = '0;
      assign q_in    = '0;
      assign dist_in = sq_root_r[RW-1];
    end else begin : g_next
      assign v_in    = dv_v_r[j-1];
      assign num_in  = dv_num_r[j-1];
      assign rem_in  = dv_rem_r[j-1];
      assign q_in    = dv_q_r[j-1];
      assign dist_in = dv_dist_r[j-1];
    end

    assign r    = {rem_in, num_in[NW-1]};
    assign diff = r - {1'b0, speed_r};
    assign ge   = (r >= {1'b0, speed_r});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_num_r[j]  <= {num_in[NW-2:0], 1'b0};
        dv_rem_r[j]  <= ge ? diff[SPEED_BITS-1:0] : r[SPEED_BITS-1:0];
        dv_q_r[j]    <= {q_in[NW-2:0], ge};
        dv_dist_r[j] <= dist_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register: saturation and zero-speed handling
  // ---------------------------------------------------------------------------
  logic [DIST_BITS-1:0]   dist_sat;
  logic [DELAY_WIDTH-1:0] delay_sat;
  logic                   spd_zero;

  assign spd_zero = (speed_r == '0);

  if (RW > DIST_BITS) begin : g_dist_clip
    assign dist_sat = (|dv_dist_r[NW-1][RW-1:DIST_BITS]) ? {DIST_BITS{1'b1}}
                                                         : dv_dist_r[NW-1][DIST_BITS-1:0];
  end else begin : g_dist_ext
    assign dist_sat = DIST_BITS'(dv_dist_r[NW-1]);
  end

  if (NW > DELAY_WIDTH) begin : g_delay_clip
    assign delay_sat = (|dv_q_r[NW-1][NW-1:DELAY_WIDTH]) ? {DELAY_WIDTH{1'b1}}
                                                         : dv_q_r[NW-1][DELAY_WIDTH-1:0];
  end else begin : g_delay_ext
    assign delay_sat = DELAY_WIDTH'(dv_q_r[NW-1]);
  end

  logic [DIST_BITS-1:0]   out_dist_r;
  logic [DELAY_WIDTH-1:0] out_delay_r;
  logic                   out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r  <= dist_sat;
      out_delay_r <= spd_zero ? '0 : delay_sat;
      out_err_r   <= spd_zero;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.distance    = out_dist_r;
  assign out_chan.delay       = out_delay_r;
  assign out_chan.speed_error = out_err_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_err_zero_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_err_r |-> out_delay_r == '0)
    else $error("speed error with nonzero delay");

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[RW-1] |-> sq_rem_r[RW-1] <= REMW'({sq_root_r[RW-1], 1'b0}))
    else $error("square root remainder out of range");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[NW-1] && !spd_zero |-> dv_rem_r[NW-1] < speed_r)
    else $error("divider remainder not below speed");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_chan.ready |=> out_v_r && $stable(out_dist_r) && $stable(out_delay_r))
    else $error("stalled result changed");

endmodule

/* dv/dcd_checker.sv */
module dcd_checker
  import dcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dcd_in_if                     in_mon,
  dcd_out_if                    out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    error_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [31:0]          delay;
    logic                 speed_error;
  } delay_result_t;

  logic [SPEED_BITS-1:0] speed_copy;
  delay_result_t         results_due[$];

  initial error_count = 0;
  assign pending_count = results_due.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic longint unsigned axis_gap(input logic signed [23:0] a,
                                               input logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d < 0 ? longint'(-d) : d;
  endfunction

  // floor square root, bit by bit from the top
  function automatic longint unsigned floor_root(input longint unsigned sq);
    longint unsigned r, c;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= sq) r = c;
    end
    return r;
  endfunction

  function automatic delay_result_t conduction(input logic signed [23:0] sx, sy, sz,
                                               input logic signed [23:0] tx, ty, tz,
                                               input logic [SPEED_BITS-1:0] spd);
    delay_result_t   res;
    longint unsigned dx, dy, dz, span, q;
    dx = axis_gap(sx, tx);
    dy = axis_gap(sy, ty);
    dz = axis_gap(sz, tz);
    span = floor_root(dx * dx + dy * dy + dz * dz);
    res.distance = (span > 64'h3FF_FFFF) ? '1 : span[DIST_BITS-1:0];
    if (spd == 0) begin
      res.delay       = '0;
      res.speed_error = 1'b1;
    end else begin
      q = (span << 8) / spd;
      res.delay       = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
      res.speed_error = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    delay_result_t want;
    if (!rst_n) begin
      speed_copy = SPEED_RESET;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t result item with nothing expected", $time);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_mon.distance !== want.distance)
            report_mismatch("distance", out_mon.distance, want.distance);
          if (out_mon.delay !== want.delay)
            report_mismatch("delay", out_mon.delay, want.delay);
          if (out_mon.speed_error !== want.speed_error)
            report_mismatch("speed_error", out_mon.speed_error, want.speed_error);
        end
      end
      if (in_mon.valid && in_mon.ready)
        results_due.push_back(conduction(in_mon.source_x, in_mon.source_y, in_mon.source_z,
                                         in_mon.target_x, in_mon.target_y, in_mon.target_z,
                                         speed_copy));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_SPEED)
        speed_copy = cfg_pwdata[SPEED_BITS-1:0];
    end
  end
endmodule

/* dv/testbench.sv */
module testbench
  import dcd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // byte addresses of the registers; the spare word is not decoded
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPEED = {REG_SPEED, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 3'd4;
  localparam int PIPE_CYCLES   = 80;    // longer than the block's pipeline, plus margin
  localparam int STALL_LIMIT   = 5000;  // cycles without any handshake or register write
  localparam int ITEMS_PER_RUN = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int error_count, pending_count;
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;

  dcd_in_if  in_chan();
  dcd_out_if out_chan();

  distance_conduction_delay dut (
    .clk, .rst_n, .in_chan, .out_chan,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  dcd_checker chk (
    .clk, .rst_n, .in_mon(in_chan), .out_mon(out_chan),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .error_count, .pending_count
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    {in_chan.source_x, in_chan.source_y, in_chan.source_z} = '0;
    {in_chan.target_x, in_chan.target_y, in_chan.target_z} = '0;
    out_chan.ready = 1'b1;
  end

  // receiver stalls at random, changes at the falling edge
  always @(negedge clk)
    out_chan.ready = ($urandom_range(99) >= stall_pct);

  // watchdog: any handshake or register write resets the count
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_psel && cfg_penable) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one item on the input channel; valid stays high between back-to-back items
  task automatic send_points(input logic [23:0] sx, sy, sz, tx, ty, tz);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid    = 1'b1;
    in_chan.source_x = sx;
    in_chan.source_y = sy;
    in_chan.source_z = sz;
    in_chan.target_x = tx;
    in_chan.target_y = ty;
    in_chan.target_z = tz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  // let the pipeline empty out completely
  task automatic drain;
    while (pending_count != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup then access, only while the pipeline is empty
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    drain();
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  function automatic logic [23:0] near_coord(input logic [23:0] base);
    return base + 24'($signed($urandom_range(8191)) - 4096);
  endfunction

  // edge cases of the coordinates, run at the reset speed and the first three written speeds
  task automatic directed_points;
    logic [23:0] lo, hi;
    lo = 24'h800000;
    hi = 24'h7FFFFF;
    send_points(0, 0, 0, 0, 0, 0);             // zero distance
    send_points(hi, hi, hi, hi, hi, hi);
    send_points(lo, lo, lo, hi, hi, hi);       // largest distance
    send_points(hi, hi, hi, lo, lo, lo);
    send_points(lo, 0, 0, hi, 0, 0);           // single axis at a time
    send_points(0, lo, 0, 0, hi, 0);
    send_points(0, 0, hi, 0, 0, lo);
    send_points(24'h000100, 0, 0, 0, 0, 0);    // exactly 1 mm
    send_points(0, 0, 0, 24'hFFFFFF, 0, 0);    // one lsb, negative side
    send_points(24'h000300, 24'h000400, 0, 0, 0, 0);   // 3-4-5 triangle
    send_points(24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'h000100, 24'h000100, 24'h000100);
    send_points(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
  endtask

  task automatic random_points(input int count);
    logic [23:0] s[3], t[3];
    for (int n = 0; n < count; n++) begin
      // every 50 items step through the idle and stall patterns
      case ((n / 50) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int a = 0; a < 3; a++) begin
        s[a] = 24'($urandom);
        // mostly nearby targets so delays stay below saturation
        t[a] = ($urandom_range(2) == 0) ? 24'($urandom) : near_coord(s[a]);
      end
      send_points(s[0], s[1], s[2], t[0], t[1], t[2]);
      // hold the sender once until everything has come back
      if (n == count / 2)
        while (pending_count != 0) @(negedge clk);
    end
  endtask

  initial begin
    logic [31:0] speeds[5];
    speeds = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(65535)), 32'd3};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset speed of 1.0 first
    directed_points();
    random_points(ITEMS_PER_RUN);
    // a write to an undecoded word must leave speed alone
    reg_write(ADDR_SPARE, 32'd7);
    directed_points();

    // then a range of speeds: slowest, zero, fastest (upper bits dropped), others
    foreach (speeds[i]) begin
      reg_write(ADDR_SPEED, speeds[i]);
      if (i < 3) directed_points();
      if (i != 2) random_points(ITEMS_PER_RUN);
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
